/* rtl/aimd_rtt_bitrate_controller_top_defines.svh */
// assertion macros shared by the aimd rate controller rtl
`ifndef AIMD_RTT_BITRATE_CONTROLLER_TOP_DEFINES_SVH
`define AIMD_RTT_BITRATE_CONTROLLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define AIMD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aimd assertion failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define AIMD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aimd assertion failed");
`else
`define AIMD_ASSERT_IMPL(lbl, ante, cons)
`define AIMD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/aimd_pkg.sv */
// types and constants of the aimd rate controller
package aimd_pkg;

    typedef logic [19:0] rate_t;

    localparam rate_t       START_RATE    = 20'd20000;
    localparam rate_t       PROBE_STEP    = 20'd1000;
    localparam rate_t       RATE_MAX      = 20'hFFFFF;
    localparam logic [31:0] DECIDE_GAP_MS = 32'd1000;

    typedef enum logic [2:0] {
        LBL_STABLE     = 3'd0,
        LBL_CONGESTED  = 3'd1,
        LBL_DECREASING = 3'd2,
        LBL_RECOVERING = 3'd3,
        LBL_PROBING    = 3'd4
    } label_t;

    typedef enum logic [2:0] {
        REG_RTT_THRESHOLD = 3'd0,
        REG_CLEAR_MARGIN  = 3'd1,
        REG_CONGEST_HOLD  = 3'd2,
        REG_CLEAR_HOLD    = 3'd3,
        REG_FLOOR_RATE    = 3'd4,
        REG_CEILING_RATE  = 3'd5,
        REG_CUT_FACTOR    = 3'd6,
        REG_GROW_FACTOR   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] rtt_threshold;
        logic [15:0] clear_margin;
        logic [15:0] congest_hold;
        logic [15:0] clear_hold;
        rate_t       floor_rate;
        rate_t       ceiling_rate;
        logic [16:0] cut_factor;
        logic [17:0] grow_factor;
    } cfg_t;

    typedef struct packed {
        logic   rate_valid;
        rate_t  new_rate;
        label_t ctrl_label;
    } result_t;

endpackage

/* rtl/aimd_core.sv */
// controller state and per-sample decision logic
`include "aimd_rtt_bitrate_controller_top_defines.svh"

module aimd_core
    import aimd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  cfg_t        cfg,
    input  logic [31:0] now_ms,
    input  logic [15:0] rtt_sample,
    output result_t     res
);

    rate_t       rate_now_reg, rate_now_next;
    rate_t       good_rate_reg, good_rate_next;
    logic        over_active_reg;
    logic [31:0] over_start_reg, over_start_next;
    logic        clear_active_reg;
    logic [31:0] clear_start_reg, clear_start_next;
    logic        decided_once_reg, decided_once_next;
    logic [31:0] last_decision_reg, last_decision_next;
    label_t      label_reg, label_next;

    logic        over_hit;
    logic        clear_hit;
    logic [31:0] over_start_eff;
    logic [31:0] clear_start_eff;
    label_t      lbl_base;
    label_t      lbl_mid;
    logic [31:0] since_dec;
    logic [31:0] over_age;
    logic [31:0] clear_age;
    logic        decide;
    logic        dec_due;
    logic        inc_due;
    logic [17:0] factor;
    logic [37:0] product;
    logic [21:0] scaled;
    rate_t       scaled_sat;
    rate_t       cut_rate;
    rate_t       ceil_eff;
    logic [23:0] nine_good;
    logic [24:0] ten_rate_inc;
    logic        below_target;
    logic [20:0] step_rate;
    logic [20:0] inc_raw;
    rate_t       inc_rate;
    logic        dec_fire;
    logic        inc_fire;

    // streak tracking
    assign over_hit  = rtt_sample > cfg.rtt_threshold;
    assign clear_hit = ({1'b0, rtt_sample} + {1'b0, cfg.clear_margin})
                       < {1'b0, cfg.rtt_threshold};

    assign over_start_eff  = (over_hit && !over_active_reg) ? now_ms : over_start_reg;
    assign clear_start_eff = (clear_hit && !clear_active_reg) ? now_ms : clear_start_reg;

    assign lbl_base = over_hit ? LBL_CONGESTED : LBL_STABLE;
    assign lbl_mid  = (label_reg == LBL_STABLE || label_reg == LBL_CONGESTED)
                      ? lbl_base : label_reg;

    // decision gating, all differences wrap mod 2^32
    assign since_dec = now_ms - last_decision_reg;
    assign over_age  = now_ms - over_start_eff;
    assign clear_age = now_ms - clear_start_eff;
    assign decide    = !(decided_once_reg && (since_dec < DECIDE_GAP_MS));
    assign dec_due   = over_hit && (over_age >= {16'd0, cfg.congest_hold});
    assign inc_due   = clear_hit && (clear_age >= {16'd0, cfg.clear_hold});

    // over and clear are exclusive, so one shared multiplier serves both paths
    assign factor     = over_hit ? {1'b0, cfg.cut_factor} : cfg.grow_factor;
    assign product    = {18'd0, rate_now_reg} * {20'd0, factor};
    assign scaled     = product[37:16];
    assign scaled_sat = (|scaled[21:20]) ? RATE_MAX : scaled[19:0];

    assign cut_rate = (scaled_sat < cfg.floor_rate) ? cfg.floor_rate : scaled_sat;
    assign ceil_eff = (cfg.ceiling_rate != '0) ? cfg.ceiling_rate : START_RATE;

    // rate < floor(9g/10)  <=>  9g >= 10r + 10
    assign nine_good    = {1'b0, good_rate_reg, 3'b000} + {4'd0, good_rate_reg};
    assign ten_rate_inc = {2'd0, rate_now_reg, 3'b000} + {4'd0, rate_now_reg, 1'b0}
                          + 25'd10;
    assign below_target = {1'b0, nine_good} >= ten_rate_inc;

    assign step_rate = {1'b0, rate_now_reg} + {1'b0, PROBE_STEP};
    assign inc_raw   = below_target ? {1'b0, scaled_sat} : step_rate;
    assign inc_rate  = (inc_raw > {1'b0, ceil_eff}) ? ceil_eff : inc_raw[19:0];

    assign dec_fire = decide && dec_due && (cut_rate != rate_now_reg);
    assign inc_fire = decide && !dec_due && inc_due && (inc_rate != rate_now_reg);

    always_comb
    begin
        rate_now_next      = rate_now_reg;
        good_rate_next     = good_rate_reg;
        over_start_next    = over_start_eff;
        clear_start_next   = clear_start_eff;
        decided_once_next  = decided_once_reg;
        last_decision_next = last_decision_reg;
        label_next         = lbl_mid;
        res.rate_valid     = 1'b0;
        res.new_rate       = '0;
        if (decide)
        begin
            decided_once_next  = 1'b1;
            last_decision_next = now_ms;
            label_next         = lbl_base;
        end
        if (dec_fire)
        begin
            good_rate_next  = rate_now_reg;
            rate_now_next   = cut_rate;
            over_start_next = now_ms;
            label_next      = LBL_DECREASING;
            res.rate_valid  = 1'b1;
            res.new_rate    = cut_rate;
        end
        else if (inc_fire)
        begin
            rate_now_next    = inc_rate;
            clear_start_next = now_ms;
            label_next       = below_target ? LBL_RECOVERING : LBL_PROBING;
            res.rate_valid   = 1'b1;
            res.new_rate     = inc_rate;
        end
        res.ctrl_label = label_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_now_reg      <= START_RATE;
            good_rate_reg     <= START_RATE;
            over_active_reg   <= 1'b0;
            over_start_reg    <= '0;
            clear_active_reg  <= 1'b0;
            clear_start_reg   <= '0;
            decided_once_reg  <= 1'b0;
            last_decision_reg <= '0;
            label_reg         <= LBL_STABLE;
        end
        else if (step)
        begin
            rate_now_reg      <= rate_now_next;
            good_rate_reg     <= good_rate_next;
            over_active_reg   <= over_hit;
            over_start_reg    <= over_start_next;
            clear_active_reg  <= clear_hit;
            clear_start_reg   <= clear_start_next;
            decided_once_reg  <= decided_once_next;
            last_decision_reg <= last_decision_next;
            label_reg         <= label_next;
        end
    end

    `AIMD_ASSERT_IMPL(a_fire_label, res.rate_valid, (res.ctrl_label == LBL_DECREASING || res.ctrl_label == LBL_RECOVERING || res.ctrl_label == LBL_PROBING))
    `AIMD_ASSERT_IMPL(a_quiet_rate_zero, !res.rate_valid, res.new_rate == '0)
    `AIMD_ASSERT_NEXT(a_no_decide_hold, step && !decide, $stable(rate_now_reg))
    `AIMD_ASSERT_NEXT(a_fire_takes_rate, step && res.rate_valid, rate_now_reg == $past(res.new_rate))

endmodule

/* rtl/aimd_rtt_bitrate_controller_top.sv */
// top level of the aimd rtt-driven bitrate controller
// a sample accepted into the sample register moves to the result register,
// which drives the result port; a blocked result side holds it back
// throughput: one sample per cycle while the result side is not stalled; the
// decision logic, with one multiplier, is combinational between those registers
// rst_n clears the controller state, the pipeline valids and the configuration
// registers to their defaults at once; the block is ready right after reset
`include "aimd_rtt_bitrate_controller_top_defines.svh"

module aimd_rtt_bitrate_controller_top
    import aimd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // sample channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] now_ms,
    input  logic [15:0] rtt_sample,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        rate_valid,
    output logic [19:0] new_rate,
    output logic [2:0]  ctrl_label,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t        cfg_reg;
    reg_idx_t    reg_idx;
    logic        cfg_wr;

    logic        in_vld_reg;
    logic [31:0] now_reg;
    logic [15:0] rtt_reg;
    logic        out_vld_reg;
    result_t     out_res_reg;

    logic        advance;
    logic        step;
    result_t     core_res;

    // ------------------------------------------------------------------
    // configuration registers, written on the access phase of a transaction
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rtt_threshold <= 16'd100;
            cfg_reg.clear_margin  <= 16'd20;
            cfg_reg.congest_hold  <= 16'd1000;
            cfg_reg.clear_hold    <= 16'd3000;
            cfg_reg.floor_rate    <= 20'd1000;
            cfg_reg.ceiling_rate  <= 20'd0;
            cfg_reg.cut_factor    <= 17'd45875;
            cfg_reg.grow_factor   <= 18'd78643;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_RTT_THRESHOLD: cfg_reg.rtt_threshold <= pwdata[15:0];
                REG_CLEAR_MARGIN:  cfg_reg.clear_margin  <= pwdata[15:0];
                REG_CONGEST_HOLD:  cfg_reg.congest_hold  <= pwdata[15:0];
                REG_CLEAR_HOLD:    cfg_reg.clear_hold    <= pwdata[15:0];
                REG_FLOOR_RATE:    cfg_reg.floor_rate    <= pwdata[19:0];
                REG_CEILING_RATE:  cfg_reg.ceiling_rate  <= pwdata[19:0];
                REG_CUT_FACTOR:    cfg_reg.cut_factor    <= pwdata[16:0];
                REG_GROW_FACTOR:   cfg_reg.grow_factor   <= pwdata[17:0];
            endcase
        end
    end

    // read back, zero-extended to the bus width
    always_comb
    begin
        unique case (reg_idx)
            REG_RTT_THRESHOLD: prdata = {16'd0, cfg_reg.rtt_threshold};
            REG_CLEAR_MARGIN:  prdata = {16'd0, cfg_reg.clear_margin};
            REG_CONGEST_HOLD:  prdata = {16'd0, cfg_reg.congest_hold};
            REG_CLEAR_HOLD:    prdata = {16'd0, cfg_reg.clear_hold};
            REG_FLOOR_RATE:    prdata = {12'd0, cfg_reg.floor_rate};
            REG_CEILING_RATE:  prdata = {12'd0, cfg_reg.ceiling_rate};
            REG_CUT_FACTOR:    prdata = {15'd0, cfg_reg.cut_factor};
            REG_GROW_FACTOR:   prdata = {14'd0, cfg_reg.grow_factor};
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control
    // the result register moves whenever it is empty or being taken; the
    // sample register stalls only when it holds a sample that cannot move
    // ------------------------------------------------------------------
    assign advance  = !out_vld_reg || !out_stall;
    assign step     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;

    // sample register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            now_reg <= now_ms;
            rtt_reg <= rtt_sample;
        end
    end

    // decision logic and controller state; state commits with each step
    aimd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cfg        (cfg_reg),
        .now_ms     (now_reg),
        .rtt_sample (rtt_reg),
        .res        (core_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_res_reg <= core_res;
        end
    end

    assign out_valid  = out_vld_reg;
    assign rate_valid = out_res_reg.rate_valid;
    assign new_rate   = out_res_reg.new_rate;
    assign ctrl_label = out_res_reg.ctrl_label;

    // a stall on the sample side only comes from a full, blocked result side
    `AIMD_ASSERT_IMPL(a_stall_needs_item, in_stall, in_vld_reg && out_vld_reg && out_stall)
    // a transaction shows up on the result side only after it sat in the sample register
    `AIMD_ASSERT_IMPL(a_out_from_in, $rose(out_vld_reg), $past(in_vld_reg))
    // an unblocked sample always reaches the result register next cycle
    `AIMD_ASSERT_NEXT(a_step_lands, step, out_vld_reg)

endmodule
